FILE: hdl/spfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spfc_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int ID_W      = 22;
    localparam int IDX_W     = 4;
    localparam int CNT_W     = 5;

    // request codes
    localparam logic [1:0] CMD_RESERVE = 2'd0;
    localparam logic [1:0] CMD_FILL    = 2'd1;
    localparam logic [1:0] CMD_CLAIM   = 2'd2;
    localparam logic [1:0] CMD_RELEASE = 2'd3;

    // result status codes
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NO_FREE   = 2'd1;
    localparam logic [1:0] STS_NO_FILLED = 2'd2;
    localparam logic [1:0] STS_NOT_BUSY  = 2'd3;

    // per-slot state codes
    localparam logic [1:0] SS_FREE   = 2'd0;
    localparam logic [1:0] SS_BUSY   = 2'd1;
    localparam logic [1:0] SS_FILLED = 2'd2;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [IDX_W-1:0] slot_index;
        logic [ID_W-1:0]  supplier_id;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] slot_out;
        logic [ID_W-1:0]  id_out;
        logic [CNT_W-1:0] free_count;
        logic [CNT_W-1:0] filled_count;
    } rsp_t;

    // write controls towards the slot store
    typedef struct packed {
        logic       stat_we;
        logic       sup_we;
        logic [1:0] state;
    } store_wr_t;

    // registered read data from the slot store
    typedef struct packed {
        logic            written;
        logic [1:0]      state;
        logic [ID_W-1:0] supplier;
    } store_rd_t;

endpackage

`default_nettype wire

FILE: hdl/spfc_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Slot state and supplier memories, one write and one registered read a cycle.
// Written bits mark never-written entries, which the reader treats as free.
module spfc_store #(
    parameter int SLOTS = spfc_pkg::SLOTS_DEF,
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [AW-1:0]                rd_addr,
    input  wire logic [AW-1:0]                wr_addr,
    input  wire spfc_pkg::store_wr_t          wr,
    input  wire logic [spfc_pkg::ID_W-1:0]    wr_supplier,
    output spfc_pkg::store_rd_t               rd
);
    import spfc_pkg::*;

    logic [1:0]      state_mem [SLOTS];
    logic [ID_W-1:0] sup_mem   [SLOTS];
    logic [SLOTS-1:0] written_reg;

    logic [1:0]      rd_state_reg;
    logic [ID_W-1:0] rd_sup_reg;
    logic            rd_written_reg;

    always_ff @(posedge clk)
    begin
        if (wr.stat_we)
        begin
            state_mem[wr_addr] <= wr.state;
        end
        if (wr.sup_we)
        begin
            sup_mem[wr_addr] <= wr_supplier;
        end
        rd_state_reg <= state_mem[rd_addr];
        rd_sup_reg   <= sup_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr.stat_we)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            rd_written_reg <= written_reg[rd_addr];
        end
    end

    assign rd.written  = rd_written_reg;
    assign rd.state    = rd_state_reg;
    assign rd.supplier = rd_sup_reg;

endmodule

`default_nettype wire

FILE: hdl/slot_pool_fill_claim_table_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Signals                      Word    Direction
// req      req_valid, req_stall, req    req_t   in  (stall driven by block)
// rsp      rsp_valid, rsp_stall, rsp    rsp_t   out (stall driven by sink)
//
// One word at a time. Reserve and claim scan the store one slot per
// cycle through a single registered read port, starting at slot 0;
// fill and release read only the named slot. A refused reserve or
// claim is answered from the counters without a scan.
// Reset sets the free count to SLOTS and clears the filled count and the written bits of the store; no clearing pass.
// req_stall is high from acceptance until the result sits in the output
// register; a stalled rsp holds the result and the next request waits.
module slot_pool_fill_claim_table_core #(
    parameter int SLOTS = spfc_pkg::SLOTS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire spfc_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output spfc_pkg::rsp_t      rsp
);
    import spfc_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_LOOK  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]      state_reg, state_next;
    req_t            req_reg;
    logic [AW-1:0]   addr_reg, addr_next;
    logic [AW-1:0]   look_addr_reg;      // address of the data now on the read port
    logic [CW-1:0]   free_cnt_reg, free_cnt_next;
    logic [CW-1:0]   filled_cnt_reg, filled_cnt_next;
    logic [1:0]      res_status_reg, res_status_next;
    logic [AW-1:0]   res_slot_reg, res_slot_next;
    logic [ID_W-1:0] res_id_reg, res_id_next;
    logic            rsp_valid_reg, rsp_valid_next;
    rsp_t            rsp_reg, rsp_next;

    store_wr_t       st_wr;
    store_rd_t       st_rd;
    logic [1:0]      eff_state;
    logic [1:0]      want_state;
    logic            hit;
    logic            idx_ok;
    logic            in_idx_ok;
    logic            accept;
    logic            out_load;

    spfc_store #(
        .SLOTS (SLOTS)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_addr     (addr_reg),
        .wr_addr     (look_addr_reg),
        .wr          (st_wr),
        .wr_supplier (req_reg.supplier_id),
        .rd          (st_rd)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign out_load  = (state_reg == ST_DONE) && (!rsp_valid_reg || !rsp_stall);

    // never-written entries are free
    assign eff_state  = st_rd.written ? st_rd.state : SS_FREE;
    assign want_state = (req_reg.cmd == CMD_CLAIM) ? SS_FILLED : SS_FREE;
    assign hit        = (eff_state == want_state);
    assign idx_ok     = (int'(req_reg.slot_index) < SLOTS);
    assign in_idx_ok  = (int'(req.slot_index) < SLOTS);

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        free_cnt_next   = free_cnt_reg;
        filled_cnt_next = filled_cnt_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_id_next     = res_id_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        st_wr           = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_START;
                    // point the read port at the named slot, or at slot 0 for a scan or an out-of-range index
                    if ((req.cmd == CMD_FILL || req.cmd == CMD_RELEASE) && in_idx_ok)
                    begin
                        addr_next = AW'(req.slot_index);
                    end
                    else
                    begin
                        addr_next = '0;
                    end
                end
            end

            ST_START:
            begin
                res_status_next = STS_OK;
                res_slot_next   = '0;
                res_id_next     = '0;
                case (req_reg.cmd)
                    CMD_RESERVE:
                    begin
                        if (free_cnt_reg == '0)
                        begin
                            res_status_next = STS_NO_FREE;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            addr_next  = addr_reg + AW'(1);
                            state_next = ST_SCAN;
                        end
                    end
                    CMD_CLAIM:
                    begin
                        if (filled_cnt_reg == '0)
                        begin
                            res_status_next = STS_NO_FILLED;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            addr_next  = addr_reg + AW'(1);
                            state_next = ST_SCAN;
                        end
                    end
                    default:
                    begin
                        if (!idx_ok)
                        begin
                            res_status_next = STS_NOT_BUSY;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_LOOK;
                        end
                    end
                endcase
            end

            ST_SCAN:
            begin
                // the counter guarantees a match before the end of the pool
                if (hit)
                begin
                    st_wr.stat_we = 1'b1;
                    st_wr.state   = SS_BUSY;
                    res_slot_next = look_addr_reg;
                    if (req_reg.cmd == CMD_CLAIM)
                    begin
                        res_id_next     = st_rd.supplier;
                        filled_cnt_next = filled_cnt_reg - CW'(1);
                    end
                    else
                    begin
                        free_cnt_next = free_cnt_reg - CW'(1);
                    end
                    state_next = ST_DONE;
                end
                else if (addr_reg != AW'(SLOTS - 1))
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end

            ST_LOOK:
            begin
                // stored ids are only ever read from filled slots, so
                // clearing them on claim or release is not needed
                if (eff_state == SS_BUSY)
                begin
                    st_wr.stat_we = 1'b1;
                    res_slot_next = look_addr_reg;
                    if (req_reg.cmd == CMD_FILL)
                    begin
                        st_wr.sup_we    = 1'b1;
                        st_wr.state     = SS_FILLED;
                        filled_cnt_next = filled_cnt_reg + CW'(1);
                    end
                    else
                    begin
                        st_wr.state   = SS_FREE;
                        free_cnt_next = free_cnt_reg + CW'(1);
                    end
                end
                else
                begin
                    res_status_next = STS_NOT_BUSY;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                // hold until the output register is free
                if (out_load)
                begin
                    rsp_next.status       = res_status_reg;
                    rsp_next.slot_out     = IDX_W'(res_slot_reg);
                    rsp_next.id_out       = res_id_reg;
                    rsp_next.free_count   = CNT_W'(free_cnt_reg);
                    rsp_next.filled_count = CNT_W'(filled_cnt_reg);
                    rsp_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            free_cnt_reg   <= CW'(SLOTS);
            filled_cnt_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_cnt_reg   <= free_cnt_next;
            filled_cnt_reg <= filled_cnt_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        addr_reg       <= addr_next;
        look_addr_reg  <= addr_reg;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_id_reg     <= res_id_next;
        rsp_reg        <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // occupancy never exceeds the pool
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(free_cnt_reg) + int'(filled_cnt_reg)) <= SLOTS)
        else $error("slot counters exceed pool size");

    // counters move only while a request is being served
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |=> ($stable(free_cnt_reg) && $stable(filled_cnt_reg)))
        else $error("slot counters changed while idle");

    // a scan only runs when its target count is non-zero
    a_scan_target: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |->
            ((req_reg.cmd == CMD_CLAIM) ? (filled_cnt_reg != '0) : (free_cnt_reg != '0)))
        else $error("scan started with empty target set");

    // a refused reserve reports an empty free count
    a_no_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && res_status_reg == STS_NO_FREE) |-> (free_cnt_reg == '0))
        else $error("no-free status with free slots left");

endmodule

`default_nettype wire
